// File: rtl/itch_message_decoder_core_defines.svh
// Assertion macros used by the checker file of the decoder.
`ifndef ITCH_MESSAGE_DECODER_CORE_DEFINES_SVH
`define ITCH_MESSAGE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, inactive while reset is asserted.
`define ITCHD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, inactive while reset is asserted.
`define ITCHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ITCHD_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/itchd_pkg.sv
package itchd_pkg;

  // Framing phase of the byte stream.
  typedef enum logic [1:0] {
    PH_LEN_HI = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  // Message kinds as reported on msg_kind.
  localparam logic [2:0] KIND_S = 3'd0;
  localparam logic [2:0] KIND_A = 3'd1;
  localparam logic [2:0] KIND_F = 3'd2;
  localparam logic [2:0] KIND_E = 3'd3;
  localparam logic [2:0] KIND_X = 3'd4;
  localparam logic [2:0] KIND_D = 3'd5;
  localparam logic [2:0] KIND_U = 3'd6;
  localparam logic [2:0] KIND_P = 3'd7;

  // Field captures of the message being received.
  typedef struct packed {
    logic [15:0] locate;
    logic [15:0] tracking;
    logic [47:0] tstamp;
    logic [63:0] ref1;
    logic [63:0] ref2;
    logic [31:0] shares;
    logic [31:0] price;
    logic [7:0]  side;
    logic [63:0] symbol;
    logic [63:0] match_num;
  } cap_t;

  // Type byte decode. Bit 3 of the result marks a known type.
  function automatic logic [3:0] kind_of(input logic [7:0] t);
    logic [3:0] k;
    case (t)
      8'h53:   k = {1'b1, KIND_S};
      8'h41:   k = {1'b1, KIND_A};
      8'h46:   k = {1'b1, KIND_F};
      8'h45:   k = {1'b1, KIND_E};
      8'h58:   k = {1'b1, KIND_X};
      8'h44:   k = {1'b1, KIND_D};
      8'h55:   k = {1'b1, KIND_U};
      8'h50:   k = {1'b1, KIND_P};
      default: k = 4'd0;
    endcase
    return k;
  endfunction

  // Body length that covers the last byte of each kind's last field.
  function automatic logic [5:0] need_len(input logic [2:0] k);
    logic [5:0] n;
    case (k)
      KIND_S:  n = 6'd12;
      KIND_A:  n = 6'd36;
      KIND_F:  n = 6'd36;
      KIND_E:  n = 6'd31;
      KIND_X:  n = 6'd23;
      KIND_D:  n = 6'd19;
      KIND_U:  n = 6'd35;
      KIND_P:  n = 6'd44;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/itchd_ifs.sv
interface itchd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source(output valid, output stream_byte, input ready);
  modport sink(input valid, input stream_byte, output ready);
endinterface

interface itchd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  msg_kind;
  logic [15:0] stock_locate;
  logic [15:0] tracking_number;
  logic [47:0] timestamp_ns;
  logic [63:0] orig_ref;
  logic [63:0] repl_ref;
  logic [31:0] shares;
  logic [31:0] price;
  logic [7:0]  side_or_event;
  logic [63:0] stock_symbol;
  logic [63:0] match_id;
  logic        too_short;

  modport source(output valid, output msg_kind, output stock_locate,
                 output tracking_number, output timestamp_ns, output orig_ref,
                 output repl_ref, output shares, output price,
                 output side_or_event, output stock_symbol, output match_id,
                 output too_short, input ready);
  modport sink(input valid, input msg_kind, input stock_locate,
               input tracking_number, input timestamp_ns, input orig_ref,
               input repl_ref, input shares, input price,
               input side_or_event, input stock_symbol, input match_id,
               input too_short, output ready);
endinterface

// File: rtl/itchd_capture.sv
module itchd_capture (
  input  itchd_pkg::cap_t cur,
  input  logic            en,
  input  logic [2:0]      kind,
  input  logic [15:0]     pos,
  input  logic [7:0]      data,
  output itchd_pkg::cap_t nxt
);
  import itchd_pkg::*;

  // ORs a byte into a big-endian field that spans body bytes first..first+n-1.
  function automatic logic [63:0] place(input logic [63:0] r, input logic [15:0] p,
                                        input logic [5:0] first, input logic [3:0] n,
                                        input logic [7:0] b);
    logic [15:0] lastb;
    logic [15:0] off;
    logic [5:0]  sh;
    lastb = {10'd0, first} + {12'd0, n} - 16'd1;
    off   = lastb - p;
    sh    = {off[2:0], 3'b000};
    if ((p >= {10'd0, first}) && (p <= lastb)) begin
      return r | ({56'd0, b} << sh);
    end
    return r;
  endfunction

  logic [63:0] t;

  always_comb begin
    nxt = cur;
    t   = 64'd0;
    if (en) begin
      t = place({48'd0, cur.locate}, pos, 6'd1, 4'd2, data);
      nxt.locate = t[15:0];
      t = place({48'd0, cur.tracking}, pos, 6'd3, 4'd2, data);
      nxt.tracking = t[15:0];
      t = place({16'd0, cur.tstamp}, pos, 6'd5, 4'd6, data);
      nxt.tstamp = t[47:0];
      if (kind == KIND_S) begin
        if (pos == 16'd11) begin
          nxt.side = data;
        end
      end else begin
        nxt.ref1 = place(cur.ref1, pos, 6'd11, 4'd8, data);
        case (kind)
          KIND_A, KIND_F, KIND_P: begin
            if (pos == 16'd19) begin
              nxt.side = data;
            end
            t = place({32'd0, cur.shares}, pos, 6'd20, 4'd4, data);
            nxt.shares = t[31:0];
            nxt.symbol = place(cur.symbol, pos, 6'd24, 4'd8, data);
            t = place({32'd0, cur.price}, pos, 6'd32, 4'd4, data);
            nxt.price = t[31:0];
            if (kind == KIND_P) begin
              nxt.match_num = place(cur.match_num, pos, 6'd36, 4'd8, data);
            end
          end
          KIND_E, KIND_X: begin
            t = place({32'd0, cur.shares}, pos, 6'd19, 4'd4, data);
            nxt.shares = t[31:0];
            if (kind == KIND_E) begin
              nxt.match_num = place(cur.match_num, pos, 6'd23, 4'd8, data);
            end
          end
          KIND_U: begin
            nxt.ref2 = place(cur.ref2, pos, 6'd19, 4'd8, data);
            t = place({32'd0, cur.shares}, pos, 6'd27, 4'd4, data);
            nxt.shares = t[31:0];
            t = place({32'd0, cur.price}, pos, 6'd31, 4'd4, data);
            nxt.price = t[31:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/itch_message_decoder_core.sv
// Channel   Direction  Payload                                   Handshake
// in_ch     sink       stream_byte (8)                           valid / ready
// out_ch    source     msg_kind .. too_short (decoded record)    valid / ready
// cfg       sink       cfg_wdata = type_enable (8)               cfg_we, no wait
//
// One stream byte is taken per cycle unless in_ch.ready is low; a decoded record is
// registered when the last body byte of an enabled message is taken.
// The result register is the only place the block can stall: in_ch.ready drops only
// when the next byte would close a frame while a record still waits in that register.
// Reset is synchronous and active low; it restores framing and enables all kinds.
module itch_message_decoder_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  itchd_in_if.sink          in_ch,
  itchd_out_if.source       out_ch
);
  import itchd_pkg::*;

  // Control state.
  phase_t      phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic        kind_vld_r, kind_vld_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [7:0]  enable_r, enable_nxt;
  logic        out_vld_r, out_vld_nxt;

  // Captures of the message in flight, and the held record.
  cap_t        cap_r, cap_nxt, cap_upd;
  cap_t        rec_r, rec_nxt;
  logic [2:0]  rec_kind_r, rec_kind_nxt;
  logic        rec_short_r, rec_short_nxt;

  logic        accept;
  logic        last_byte;
  logic [3:0]  kind_dec;
  logic        emit;
  logic [16:0] pos_inc;

  // The frame closes on the byte at the final body position, whatever its value,
  // so the stall decision depends on state and out_ch.ready, not on the byte.
  assign pos_inc   = {1'b0, pos_r} + 17'd1;
  assign last_byte = (phase_r == PH_BODY) && (pos_inc >= {1'b0, len_r});
  assign in_ch.ready = !last_byte || !out_vld_r || out_ch.ready;
  assign accept    = in_ch.valid && in_ch.ready;
  assign kind_dec  = kind_of(in_ch.stream_byte);

  // Field placement for every body byte after the type byte of a known type.
  itchd_capture u_capture (
    .cur  (cap_r),
    .en   (kind_vld_r && (pos_r != 16'd0)),
    .kind (kind_r),
    .pos  (pos_r),
    .data (in_ch.stream_byte),
    .nxt  (cap_upd)
  );

  always_comb begin
    phase_nxt     = phase_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    kind_vld_nxt  = kind_vld_r;
    kind_nxt      = kind_r;
    cap_nxt       = cap_r;
    rec_nxt       = rec_r;
    rec_kind_nxt  = rec_kind_r;
    rec_short_nxt = rec_short_r;
    enable_nxt    = cfg_we ? cfg_wdata : enable_r;
    emit          = 1'b0;
    out_vld_nxt   = out_vld_r && !out_ch.ready;

    if (accept) begin
      case (phase_r)
        PH_LEN_HI: begin
          len_nxt   = {in_ch.stream_byte, 8'd0};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          // A new frame starts clean; an empty frame goes straight back to framing.
          len_nxt      = {len_r[15:8], in_ch.stream_byte};
          pos_nxt      = 16'd0;
          kind_vld_nxt = 1'b0;
          kind_nxt     = KIND_S;
          cap_nxt      = '0;
          phase_nxt    = ({len_r[15:8], in_ch.stream_byte} == 16'd0) ? PH_LEN_HI : PH_BODY;
        end
        PH_BODY: begin
          if (pos_r == 16'd0) begin
            kind_vld_nxt = kind_dec[3];
            kind_nxt     = kind_dec[2:0];
          end else begin
            cap_nxt = cap_upd;
          end
          if (last_byte) begin
            // The record is built from the captures including this final byte.
            phase_nxt     = PH_LEN_HI;
            pos_nxt       = 16'd0;
            emit          = kind_vld_nxt && enable_r[kind_nxt];
            rec_nxt       = cap_nxt;
            rec_kind_nxt  = kind_nxt;
            rec_short_nxt = len_r < {10'd0, need_len(kind_nxt)};
          end else begin
            pos_nxt = pos_inc[15:0];
          end
        end
        default: begin
          phase_nxt = PH_LEN_HI;
        end
      endcase
    end

    if (emit) begin
      out_vld_nxt = 1'b1;
    end else begin
      rec_nxt       = rec_r;
      rec_kind_nxt  = rec_kind_r;
      rec_short_nxt = rec_short_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEN_HI;
      len_r      <= 16'd0;
      pos_r      <= 16'd0;
      kind_vld_r <= 1'b0;
      kind_r     <= KIND_S;
      enable_r   <= 8'hFF;
      out_vld_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      len_r      <= len_nxt;
      pos_r      <= pos_nxt;
      kind_vld_r <= kind_vld_nxt;
      kind_r     <= kind_nxt;
      enable_r   <= enable_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers carry no reset; a new frame clears the captures.
  always_ff @(posedge clk) begin
    cap_r       <= cap_nxt;
    rec_r       <= rec_nxt;
    rec_kind_r  <= rec_kind_nxt;
    rec_short_r <= rec_short_nxt;
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.msg_kind        = rec_kind_r;
  assign out_ch.stock_locate    = rec_r.locate;
  assign out_ch.tracking_number = rec_r.tracking;
  assign out_ch.timestamp_ns    = rec_r.tstamp;
  assign out_ch.orig_ref        = rec_r.ref1;
  assign out_ch.repl_ref        = rec_r.ref2;
  assign out_ch.shares          = rec_r.shares;
  assign out_ch.price           = rec_r.price;
  assign out_ch.side_or_event   = rec_r.side;
  assign out_ch.stock_symbol    = rec_r.symbol;
  assign out_ch.match_id        = rec_r.match_num;
  assign out_ch.too_short       = rec_short_r;

endmodule

// File: rtl/itch_message_decoder_core_chk.sv
`include "itch_message_decoder_core_defines.svh"

module itch_message_decoder_core_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [63:0] out_orig_ref,
  input logic        out_too_short
);

  // A waiting record keeps its kind, original reference and short flag until it is taken.
  `ITCHD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                     out_valid && $stable(out_kind) && $stable(out_orig_ref)
                     && $stable(out_too_short), "record changed while stalled")

  // The input side stalls only behind a record that is not being taken.
  `ITCHD_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready,
                    "input stalled without a waiting record")

  // A new record follows an accepted byte.
  `ITCHD_ASSERT_NOW(a_rec_source, $rose(out_valid), $past(in_valid && in_ready),
                    "record without an accepted byte")

  // Reset empties the result register.
  `ITCHD_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "record present after reset")

endmodule

bind itch_message_decoder_core itch_message_decoder_core_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_kind      (out_ch.msg_kind),
  .out_orig_ref  (out_ch.orig_ref),
  .out_too_short (out_ch.too_short)
);
